@@ design/ftt_pkg.sv @@
`default_nettype none
package ftt_pkg;
	localparam int unsigned FieldW = 12;
	localparam int unsigned TimeW = 32;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned ReportLimit = 16;

	localparam logic [1:0] KIND_DET = 2'd0;
	localparam logic [1:0] KIND_ENTRY = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;

	localparam logic CMD_DETECT = 1'b0;
	localparam logic CMD_EOF = 1'b1;

	localparam logic [CfgIdxW-1:0] REG_TOL = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_EXPIRE = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_CAPTURE = 2'd2;

	typedef struct packed {
		logic [FieldW-1:0] x;
		logic [FieldW-1:0] y;
		logic [FieldW-1:0] w;
		logic [FieldW-1:0] h;
	} rect_t;

	typedef struct packed {
		rect_t rect;
		logic [TimeW-1:0] first_seen;
		logic [TimeW-1:0] last_seen;
	} entry_t;

	typedef struct packed {
		logic command;
		logic [FieldW-1:0] rect_x;
		logic [FieldW-1:0] rect_y;
		logic [FieldW-1:0] rect_width;
		logic [FieldW-1:0] rect_height;
		logic [TimeW-1:0] timestamp_ms;
	} item_in_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] slot;
		logic [FieldW-1:0] report_x;
		logic [FieldW-1:0] report_y;
		logic [FieldW-1:0] report_width;
		logic [FieldW-1:0] report_height;
		logic new_track;
		logic dropped;
		logic dwell_reached;
		logic last;
	} item_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MATCH,
		ST_DET_DONE,
		ST_COMPACT,
		ST_REPORT
	} state_t;

	function automatic logic close_enough(logic [FieldW-1:0] a, logic [FieldW-1:0] b,
			logic [FieldW-1:0] tol);
		logic [FieldW-1:0] d;
		d = (a > b) ? a - b : b - a;
		return d < tol;
	endfunction
endpackage
`default_nettype wire

@@ design/face_track_table.sv @@
// face track table: detections update or append entries, end of frame expires and reports
// detection: table walk, one entry read per cycle from the ram, ending at the first match or the end of the table
// end of frame: a compaction walk keeps the live entries, then reports them, each read issued after the previous report
// result transfers last one cycle on strobe; the receiver cannot stall
// arst_n clears the entry count and control and loads the config registers with defaults; ram content is undefined
`default_nettype none
module face_track_table #(
	parameter int unsigned MAX_TRACKS = 16
) (
	input wire clk,
	input wire arst_n,
	input wire start,
	output logic busy,
	input wire ftt_pkg::item_in_t item,
	output logic strobe,
	output ftt_pkg::item_out_t result,
	input wire cfg_we,
	input wire [ftt_pkg::CfgIdxW-1:0] cfg_index,
	input wire [ftt_pkg::TimeW-1:0] cfg_data
);
	import ftt_pkg::*;

	localparam int unsigned AW = $clog2(MAX_TRACKS);
	localparam int unsigned CW = $clog2(MAX_TRACKS + 1);

	logic [FieldW-1:0] tol_q;
	logic [TimeW-1:0] expire_q, capture_q;

	state_t state_q, state_d;
	logic [CW-1:0] count_q, rd_q, kept_q, rep_q;
	logic pend_q;          // read issued last cycle, data valid now
	logic [AW-1:0] pend_idx_q;
	item_in_t it_q;
	logic matched_q;
	logic [AW-1:0] hit_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	entry_t wdata, rdata;

	ftt_entry_ram #(.DEPTH(MAX_TRACKS), .AW(AW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	rect_t det;
	assign det = '{x: it_q.rect_x, y: it_q.rect_y, w: it_q.rect_width, h: it_q.rect_height};

	logic hit, alive;
	assign hit = close_enough(det.x, rdata.rect.x, tol_q) &&
		close_enough(det.y, rdata.rect.y, tol_q) &&
		close_enough(det.w, rdata.rect.w, tol_q) &&
		close_enough(det.h, rdata.rect.h, tol_q);
	assign alive = (it_q.timestamp_ms - rdata.last_seen) < expire_q;

	logic walk_done;
	assign walk_done = (rd_q == count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= FieldW'(50);
			expire_q <= TimeW'(2000);
			capture_q <= TimeW'(10000);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TOL: tol_q <= cfg_data[FieldW-1:0];
				REG_EXPIRE: expire_q <= cfg_data;
				REG_CAPTURE: capture_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = (item.command == CMD_EOF) ? ST_COMPACT : ST_MATCH;
			ST_MATCH: if ((pend_q && hit) || (walk_done && !pend_q)) state_d = ST_DET_DONE;
			ST_DET_DONE: state_d = ST_IDLE;
			ST_COMPACT: if (walk_done && !pend_q) state_d = (kept_q == '0) ? ST_IDLE : ST_REPORT;
			ST_REPORT: if (pend_q && (rep_q + CW'(1) == kept_q || rep_q == CW'(ReportLimit - 1) ||
				rep_q + CW'(1) == CW'(MAX_TRACKS))) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// ram access, outputs
	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = rdata;
		raddr = rd_q[AW-1:0];
		busy = (state_q != ST_IDLE);
		strobe = 1'b0;
		result = '0;
		unique case (state_q)
			ST_MATCH: if (pend_q && hit) begin
				we = 1'b1;
				waddr = pend_idx_q;
				wdata.rect = det;
				wdata.last_seen = it_q.timestamp_ms;
			end
			ST_DET_DONE: begin
				strobe = 1'b1;
				result.kind = KIND_DET;
				result.report_x = det.x;
				result.report_y = det.y;
				result.report_width = det.w;
				result.report_height = det.h;
				result.last = 1'b1;
				if (matched_q) begin
					result.slot = 4'(hit_q);
				end else if (count_q < CW'(MAX_TRACKS)) begin
					result.slot = 4'(count_q);
					result.new_track = 1'b1;
					we = 1'b1;
					waddr = count_q[AW-1:0];
					wdata = '{rect: det, first_seen: it_q.timestamp_ms,
						last_seen: it_q.timestamp_ms};
				end else begin
					result.dropped = 1'b1;
				end
			end
			ST_COMPACT: begin
				if (pend_q && alive) begin
					we = 1'b1;
					waddr = kept_q[AW-1:0];
				end
				if (walk_done && !pend_q && kept_q == '0) begin
					strobe = 1'b1;
					result.kind = KIND_EMPTY;
					result.last = 1'b1;
				end
			end
			ST_REPORT: begin
				raddr = rd_q[AW-1:0];
				if (pend_q) begin
					strobe = 1'b1;
					result.kind = KIND_ENTRY;
					result.slot = 4'(rep_q);
					result.report_x = rdata.rect.x;
					result.report_y = rdata.rect.y;
					result.report_width = rdata.rect.w;
					result.report_height = rdata.rect.h;
					result.dwell_reached = (it_q.timestamp_ms - rdata.first_seen) >= capture_q;
					result.last = (state_d == ST_IDLE);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			rd_q <= '0;
			kept_q <= '0;
			rep_q <= '0;
			pend_q <= 1'b0;
			pend_idx_q <= '0;
			matched_q <= 1'b0;
			hit_q <= '0;
		end else begin
			state_q <= state_d;
			pend_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					rd_q <= '0;
					kept_q <= '0;
					rep_q <= '0;
					matched_q <= 1'b0;
				end
				ST_MATCH: begin
					if (pend_q && hit) begin
						matched_q <= 1'b1;
						hit_q <= pend_idx_q;
					end else if (!walk_done) begin
						pend_q <= 1'b1;
						pend_idx_q <= rd_q[AW-1:0];
						rd_q <= rd_q + CW'(1);
					end
				end
				ST_DET_DONE: if (!matched_q && count_q < CW'(MAX_TRACKS)) count_q <= count_q + CW'(1);
				ST_COMPACT: begin
					if (pend_q && alive) kept_q <= kept_q + CW'(1);
					if (!walk_done) begin
						pend_q <= 1'b1;
						rd_q <= rd_q + CW'(1);
					end
					if (walk_done && !pend_q) begin
						count_q <= kept_q;
						rd_q <= '0;
					end
				end
				ST_REPORT: begin
					if (pend_q) rep_q <= rep_q + CW'(1);
					if (!pend_q) begin
						pend_q <= 1'b1;
						rd_q <= rd_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) it_q <= item;
	end
endmodule
`default_nettype wire

@@ design/ftt_entry_ram.sv @@
`default_nettype none
module ftt_entry_ram #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW = 4
) (
	input wire clk,
	input wire we,
	input wire [AW-1:0] waddr,
	input wire ftt_pkg::entry_t wdata,
	input wire [AW-1:0] raddr,
	output ftt_pkg::entry_t rdata
);
	import ftt_pkg::*;

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire
